@@ src/rvwap_pkg.sv @@
// Shared types and constants for the rolling three-window VWAP block.
// No dependencies; every other file refers to this package by scoped names.
package rvwap_pkg;

   localparam int MAX_WINDOW_DEF = 32;

   localparam int WIN_W    = 6;
   localparam int AMOUNT_W = 48;
   localparam int VOLUME_W = 40;
   localparam int ASUM_W   = 53;
   localparam int VSUM_W   = 45;
   localparam int AVG_W    = 32;
   localparam int NUM_WIN  = 3;

   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_WINDOW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MID_WINDOW   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_WINDOW  = 2'd2;

   localparam logic [WIN_W-1:0] SHORT_WINDOW_RST = 6'd5;
   localparam logic [WIN_W-1:0] MID_WINDOW_RST   = 6'd10;
   localparam logic [WIN_W-1:0] LONG_WINDOW_RST  = 6'd20;

   typedef enum logic [1:0] {
      WIN_SHORT = 2'd0,
      WIN_MID   = 2'd1,
      WIN_LONG  = 2'd2
   } win_sel_type;

   typedef struct packed {
      logic                series_start;
      logic [AMOUNT_W-1:0] trade_amount;
      logic [VOLUME_W-1:0] trade_volume;
   } req_type;

   typedef struct packed {
      logic [AVG_W-1:0] avg_short;
      logic [AVG_W-1:0] avg_mid;
      logic [AVG_W-1:0] avg_long;
      logic             short_valid;
      logic             mid_valid;
      logic             long_valid;
   } rsp_type;

   typedef struct packed {
      logic        load;
      logic        read;
      logic        update;
      logic        div_start;
      logic        finish;
      win_sel_type sel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_done;
   } dp_status_type;

endpackage

@@ src/rolling_vwap_three_windows_top.sv @@
// Top level of the rolling three-window VWAP block: sequencer plus datapath.
// Depends on rvwap_pkg, rvwap_ctrl, rvwap_dp (and through it rvwap_div).
//
//   Port group  Direction  Handshake            Payload
//   req_        in         req_valid/req_ready  req_data (rvwap_pkg::req_type)
//   rsp_        out        rsp_valid/rsp_ready  rsp_data (rvwap_pkg::rsp_type)
//   csr_        in         csr_we only          csr_index, csr_wdata
//
// A transaction passes from acceptance to the output register in steps: it is accepted,
// then for each of the three windows the oldest point is read, the sums are updated, the
// shared divider is started and the sequencer waits for its 32 quotient bits and the
// hand-over (sooner when the volume sum is zero or the quotient saturates); last, the
// result is loaded. Reset is synchronous and needs no clearing pass. The result
// sits in an output register, so a new transaction is accepted while it waits; only the
// hand-over of the next result waits for rsp_ready.
module rolling_vwap_three_windows_top #(
   parameter int MAX_WINDOW = rvwap_pkg::MAX_WINDOW_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  rvwap_pkg::req_type              req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output rvwap_pkg::rsp_type              rsp_data,
   input  logic                            csr_we,
   input  logic [rvwap_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rvwap_pkg::WIN_W-1:0]     csr_wdata
);

   rvwap_pkg::ctrl_cmd_type  cmd;
   rvwap_pkg::dp_status_type status;

   rvwap_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   rvwap_dp #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_one_command : assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.read, cmd.update, cmd.div_start, cmd.finish}))
      else $error("more than one datapath command in a cycle");

   a_update_after_read : assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> $past(cmd.read))
      else $error("sum update without a preceding history read");

   a_div_after_update : assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> $past(cmd.update))
      else $error("divider started on a stale sum");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid || rsp_ready))
      else $error("pending result overwritten");
`endif

endmodule

@@ src/rvwap_ctrl.sv @@
// Sequencer for the rolling VWAP block: walks each transaction through the
// three windows and hands the result to the output register. Uses rvwap_pkg.
module rvwap_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rvwap_pkg::ctrl_cmd_type  cmd,
   input  rvwap_pkg::dp_status_type status
);

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_READ      = 6'b000010,
      ST_UPDATE    = 6'b000100,
      ST_DIV_START = 6'b001000,
      ST_DIV_WAIT  = 6'b010000,
      ST_FINISH    = 6'b100000
   } state_type;

   state_type              state_ff, state_in;
   rvwap_pkg::win_sel_type sel_ff, sel_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in      = state_ff;
      sel_in        = sel_ff;
      req_ready     = 1'b0;
      cmd.load      = 1'b0;
      cmd.read      = 1'b0;
      cmd.update    = 1'b0;
      cmd.div_start = 1'b0;
      cmd.finish    = 1'b0;
      cmd.sel       = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               sel_in   = rvwap_pkg::WIN_SHORT;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_DIV_START;
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               case (sel_ff)
                  rvwap_pkg::WIN_SHORT: begin
                     sel_in   = rvwap_pkg::WIN_MID;
                     state_in = ST_READ;
                  end
                  rvwap_pkg::WIN_MID: begin
                     sel_in   = rvwap_pkg::WIN_LONG;
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_FINISH: begin
            // The output register is only reloaded once the previous
            // transaction has been taken.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= rvwap_pkg::WIN_SHORT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ src/rvwap_div.sv @@
// Radix-2 restoring divider producing a saturated 32-bit quotient of a
// window amount sum by its volume sum, one quotient bit per cycle. Uses rvwap_pkg.
module rvwap_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [rvwap_pkg::ASUM_W-1:0]   dividend,
   input  logic [rvwap_pkg::VSUM_W-1:0]   divisor,
   output logic                           done,
   output logic [rvwap_pkg::AVG_W-1:0]    quotient,
   output logic                           nonzero
);

   localparam int HI_W  = rvwap_pkg::ASUM_W - rvwap_pkg::AVG_W;
   localparam int REM_W = rvwap_pkg::VSUM_W + 1;
   localparam int CNT_W = $clog2(rvwap_pkg::AVG_W);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [REM_W-1:0]              rem_ff, rem_in;
   logic [rvwap_pkg::AVG_W-1:0]   low_ff, low_in;
   logic [rvwap_pkg::VSUM_W-1:0]  dvs_ff, dvs_in;
   logic [rvwap_pkg::AVG_W-1:0]   quo_ff, quo_in;
   logic                          ok_ff, ok_in;

   logic [REM_W-1:0] trial;
   logic [REM_W-1:0] diff;
   logic             fits;
   logic [HI_W-1:0]  dividend_hi;

   assign dividend_hi = dividend[rvwap_pkg::ASUM_W-1:rvwap_pkg::AVG_W];
   assign trial       = {rem_ff[REM_W-2:0], low_ff[rvwap_pkg::AVG_W-1]};
   assign fits        = trial >= {1'b0, dvs_ff};
   assign diff        = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      ok_in   = ok_ff;
      if (start) begin
         if (divisor == '0) begin
            quo_in  = '0;
            ok_in   = 1'b0;
            done_in = 1'b1;
         end else if (rvwap_pkg::VSUM_W'(dividend_hi) >= divisor) begin
            // The quotient needs more than 32 bits, so it saturates.
            quo_in  = '1;
            ok_in   = 1'b1;
            done_in = 1'b1;
         end else begin
            // The upper part is below the divisor, so it is the first remainder.
            rem_in  = REM_W'(dividend_hi);
            low_in  = dividend[rvwap_pkg::AVG_W-1:0];
            dvs_in  = divisor;
            quo_in  = '0;
            ok_in   = 1'b1;
            cnt_in  = CNT_W'(rvwap_pkg::AVG_W - 1);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = fits ? diff : trial;
         quo_in = {quo_ff[rvwap_pkg::AVG_W-2:0], fits};
         low_in = {low_ff[rvwap_pkg::AVG_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
      ok_ff  <= ok_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
   assign nonzero  = ok_ff;

endmodule

@@ src/rvwap_dp.sv @@
// Datapath of the rolling VWAP block: window registers, point history memory,
// running sums, the shared divider and the output register. Uses rvwap_pkg, rvwap_div.
module rvwap_dp #(
   parameter int MAX_WINDOW = rvwap_pkg::MAX_WINDOW_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  rvwap_pkg::req_type                req_data,
   input  logic                              csr_we,
   input  logic [rvwap_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rvwap_pkg::WIN_W-1:0]       csr_wdata,
   input  rvwap_pkg::ctrl_cmd_type           cmd,
   output rvwap_pkg::dp_status_type          status,
   output rvwap_pkg::rsp_type                rsp_data
);

   localparam int SLOT_W = $clog2(MAX_WINDOW);
   localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
   localparam int CMP_W  = (CNT_W > rvwap_pkg::WIN_W) ? CNT_W : rvwap_pkg::WIN_W;
   localparam int OLD_W  = CNT_W + 1;

   logic [rvwap_pkg::WIN_W-1:0]    win_ff [rvwap_pkg::NUM_WIN];
   logic [rvwap_pkg::WIN_W-1:0]    win_in [rvwap_pkg::NUM_WIN];
   logic [SLOT_W-1:0]              slot_ff, slot_in;
   logic [CNT_W-1:0]               seen_ff, seen_in;
   logic [rvwap_pkg::ASUM_W-1:0]   asum_ff [rvwap_pkg::NUM_WIN];
   logic [rvwap_pkg::ASUM_W-1:0]   asum_in [rvwap_pkg::NUM_WIN];
   logic [rvwap_pkg::VSUM_W-1:0]   vsum_ff [rvwap_pkg::NUM_WIN];
   logic [rvwap_pkg::VSUM_W-1:0]   vsum_in [rvwap_pkg::NUM_WIN];

   logic [rvwap_pkg::AMOUNT_W-1:0] amount_ff;
   logic [rvwap_pkg::VOLUME_W-1:0] volume_ff;
   logic [rvwap_pkg::AMOUNT_W-1:0] amount_hist_ff [MAX_WINDOW];
   logic [rvwap_pkg::VOLUME_W-1:0] volume_hist_ff [MAX_WINDOW];
   logic [rvwap_pkg::AMOUNT_W-1:0] amount_old_ff;
   logic [rvwap_pkg::VOLUME_W-1:0] volume_old_ff;

   logic [rvwap_pkg::AVG_W-1:0]    avg_ff [rvwap_pkg::NUM_WIN];
   logic                           avg_ok_ff [rvwap_pkg::NUM_WIN];
   rvwap_pkg::rsp_type             rsp_ff;

   logic [rvwap_pkg::WIN_W-1:0]    win_cur;
   logic [CMP_W-1:0]               win_ext;
   logic [CMP_W-1:0]               eff_c;
   logic [CNT_W-1:0]               eff;
   logic [OLD_W-1:0]               slot_ext;
   logic [OLD_W-1:0]               old_w;
   logic [SLOT_W-1:0]              old_slot;
   logic                           drop_old;
   logic [rvwap_pkg::ASUM_W-1:0]   asum_upd;
   logic [rvwap_pkg::VSUM_W-1:0]   vsum_upd;
   logic                           csr_hit;
   logic                           restart;

   logic                           div_done;
   logic [rvwap_pkg::AVG_W-1:0]    div_quotient;
   logic                           div_nonzero;

   // Effective length of the selected window: zero counts as one, and
   // anything beyond the history depth is clamped to it.
   always_comb begin
      win_cur = win_ff[cmd.sel];
      win_ext = CMP_W'(win_cur);
      if (win_ext == '0) begin
         eff_c = CMP_W'(1);
      end else if (win_ext > CMP_W'(MAX_WINDOW)) begin
         eff_c = CMP_W'(MAX_WINDOW);
      end else begin
         eff_c = win_ext;
      end
      eff = eff_c[CNT_W-1:0];
   end

   always_comb begin
      slot_ext = OLD_W'(slot_ff);
      if (slot_ext >= OLD_W'(eff)) begin
         old_w = slot_ext - OLD_W'(eff);
      end else begin
         old_w = slot_ext + OLD_W'(MAX_WINDOW) - OLD_W'(eff);
      end
      old_slot = old_w[SLOT_W-1:0];
      drop_old = seen_ff >= eff;
   end

   assign asum_upd = asum_ff[cmd.sel] + rvwap_pkg::ASUM_W'(amount_ff)
                   - (drop_old ? rvwap_pkg::ASUM_W'(amount_old_ff) : '0);
   assign vsum_upd = vsum_ff[cmd.sel] + rvwap_pkg::VSUM_W'(volume_ff)
                   - (drop_old ? rvwap_pkg::VSUM_W'(volume_old_ff) : '0);

   always_comb begin
      win_in  = win_ff;
      slot_in = slot_ff;
      seen_in = seen_ff;
      asum_in = asum_ff;
      vsum_in = vsum_ff;
      csr_hit = 1'b0;
      if (csr_we) begin
         case (csr_index)
            rvwap_pkg::CSR_SHORT_WINDOW: begin
               win_in[rvwap_pkg::WIN_SHORT] = csr_wdata;
               csr_hit = 1'b1;
            end
            rvwap_pkg::CSR_MID_WINDOW: begin
               win_in[rvwap_pkg::WIN_MID] = csr_wdata;
               csr_hit = 1'b1;
            end
            rvwap_pkg::CSR_LONG_WINDOW: begin
               win_in[rvwap_pkg::WIN_LONG] = csr_wdata;
               csr_hit = 1'b1;
            end
            default: begin
               csr_hit = 1'b0;
            end
         endcase
      end
      if (cmd.update) begin
         asum_in[cmd.sel] = asum_upd;
         vsum_in[cmd.sel] = vsum_upd;
      end
      if (cmd.finish) begin
         slot_in = (slot_ff == SLOT_W'(MAX_WINDOW - 1)) ? '0 : slot_ff + 1'b1;
         seen_in = (seen_ff == CNT_W'(MAX_WINDOW)) ? seen_ff : seen_ff + 1'b1;
      end
      // A new window length or a series start empties every window.
      restart = csr_hit || (cmd.load && req_data.series_start);
      if (restart) begin
         slot_in = '0;
         seen_in = '0;
         for (int k = 0; k < rvwap_pkg::NUM_WIN; k++) begin
            asum_in[k] = '0;
            vsum_in[k] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff[rvwap_pkg::WIN_SHORT] <= rvwap_pkg::SHORT_WINDOW_RST;
         win_ff[rvwap_pkg::WIN_MID]   <= rvwap_pkg::MID_WINDOW_RST;
         win_ff[rvwap_pkg::WIN_LONG]  <= rvwap_pkg::LONG_WINDOW_RST;
         slot_ff <= '0;
         seen_ff <= '0;
         for (int k = 0; k < rvwap_pkg::NUM_WIN; k++) begin
            asum_ff[k] <= '0;
            vsum_ff[k] <= '0;
         end
      end else begin
         win_ff  <= win_in;
         slot_ff <= slot_in;
         seen_ff <= seen_in;
         asum_ff <= asum_in;
         vsum_ff <= vsum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         amount_ff <= req_data.trade_amount;
         volume_ff <= req_data.trade_volume;
      end
   end

   // Point history: one write at the end of a transaction, one registered
   // read of the oldest point of the window being processed.
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         amount_hist_ff[slot_ff] <= amount_ff;
         volume_hist_ff[slot_ff] <= volume_ff;
      end
      if (cmd.read) begin
         amount_old_ff <= amount_hist_ff[old_slot];
         volume_old_ff <= volume_hist_ff[old_slot];
      end
   end

   rvwap_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (asum_ff[cmd.sel]),
      .divisor  (vsum_ff[cmd.sel]),
      .done     (div_done),
      .quotient (div_quotient),
      .nonzero  (div_nonzero)
   );

   always_ff @(posedge clock) begin
      if (div_done) begin
         avg_ff[cmd.sel]    <= div_quotient;
         avg_ok_ff[cmd.sel] <= div_nonzero;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff.avg_short   <= avg_ff[rvwap_pkg::WIN_SHORT];
         rsp_ff.avg_mid     <= avg_ff[rvwap_pkg::WIN_MID];
         rsp_ff.avg_long    <= avg_ff[rvwap_pkg::WIN_LONG];
         rsp_ff.short_valid <= avg_ok_ff[rvwap_pkg::WIN_SHORT];
         rsp_ff.mid_valid   <= avg_ok_ff[rvwap_pkg::WIN_MID];
         rsp_ff.long_valid  <= avg_ok_ff[rvwap_pkg::WIN_LONG];
      end
   end

   assign status.div_done = div_done;
   assign rsp_data        = rsp_ff;

endmodule
